### rtl/core/sle_pkg.sv
// Shared constants and codes for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

   localparam int DATA_W       = 32;
   localparam int DEF_CAPACITY = 128;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_LOCATE = 3'd2;
   localparam logic [2:0] ACT_GET    = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_BAD_POS   = 3'd1;
   localparam logic [2:0] STS_FULL      = 3'd2;
   localparam logic [2:0] STS_EMPTY     = 3'd3;
   localparam logic [2:0] STS_NOT_FOUND = 3'd4;

endpackage

### rtl/core/sle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sle_ram
   import sle_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = DEF_CAPACITY,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sequential_list_engine_core.sv
// Top level of the sequential list engine: command sequencer around the entry RAM.
`timescale 1ns / 1ps
// Clear, rejects and unused codes answer straight from idle; get reads one entry; locate
//   reads from the head up to the first hit or the end; insert/delete shift the entries past p.
// One command at a time; busy drops as the result beat is driven, so the next command can
//   be taken at the edge ending that beat.
// Reset clears the length and the sequencer only; RAM entries stay undefined until written.
// The receiver cannot stall: each result beat is on the rsp_ ports for exactly one cycle.

module sequential_list_engine_core
   import sle_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic [7:0]         rsp_found_position,
   output logic [7:0]         rsp_list_length,
   output logic               rsp_is_empty
);

   // RAM address width, length width, and a common width for position compares.
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > 8) ? CW : 8) + 1;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type         state_ff;
   logic [2:0]        act_ff;
   logic [AW-1:0]     pos0_ff;     // zero-based target position
   logic [31:0]       val_ff;
   logic [CW-1:0]     count_ff;
   logic [AW-1:0]     idx_ff;      // next RAM address to read
   logic [CW-1:0]     left_ff;     // reads still to issue
   logic              pend_ff;     // a read is in flight, data shows this cycle
   logic [AW-1:0]     paddr_ff;    // address of the read in flight

   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [31:0]       rsp_element_ff;
   logic [7:0]        rsp_found_ff;
   logic [7:0]        rsp_len_ff;
   logic              rsp_empty_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [31:0]       ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [31:0]       ram_rdata;

   logic [EW-1:0]     pos_e;
   logic [EW-1:0]     cnt_e;
   logic [EW-1:0]     found_e;
   logic              accept;
   logic              walk_end;

   assign accept   = start && (state_ff == ST_IDLE);
   assign pos_e    = EW'(req_position);
   assign cnt_e    = EW'(count_ff);
   assign found_e  = EW'(paddr_ff) + EW'(1);
   assign walk_end = (left_ff == '0) && !pend_ff;

   function automatic logic [7:0] low8(input logic [CW-1:0] x);
      logic [EW-1:0] w;
      w = EW'(x);
      return w[7:0];
   endfunction

   // RAM port steering: shift writes land in the cycle after their reads are issued.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = paddr_ff;
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff;
      if (state_ff == ST_WALK) begin
         if (pend_ff && (act_ff == ACT_INSERT)) begin
            ram_we    = 1'b1;
            ram_waddr = paddr_ff + AW'(1);
         end else if (pend_ff && (act_ff == ACT_DELETE)) begin
            ram_we    = 1'b1;
            ram_waddr = paddr_ff - AW'(1);
         end else if (walk_end && (act_ff == ACT_INSERT)) begin
            // port is free once the last shift write has landed: drop the new value in
            ram_we    = 1'b1;
            ram_waddr = pos0_ff;
            ram_wdata = val_ff;
         end
      end
   end

   sle_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         left_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  act_ff         <= req_action;
                  pos0_ff        <= AW'(pos_e - EW'(1));
                  val_ff         <= req_value;
                  pend_ff        <= 1'b0;
                  rsp_status_ff  <= STS_OK;
                  rsp_element_ff <= '0;
                  rsp_found_ff   <= '0;
                  rsp_len_ff     <= low8(count_ff);
                  rsp_empty_ff   <= (count_ff == '0);
                  case (req_action)
                     ACT_INSERT: begin
                        if ((pos_e == '0) || (pos_e > cnt_e + EW'(1))) begin
                           rsp_status_ff <= STS_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else if (cnt_e >= EW'(CAPACITY)) begin
                           rsp_status_ff <= STS_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           idx_ff   <= AW'(cnt_e - EW'(1));
                           left_ff  <= CW'(cnt_e - pos_e + EW'(1));
                           state_ff <= ST_WALK;
                        end
                     end
                     ACT_DELETE: begin
                        if (count_ff == '0) begin
                           rsp_status_ff <= STS_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end else if ((pos_e == '0) || (pos_e > cnt_e)) begin
                           rsp_status_ff <= STS_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           idx_ff   <= AW'(pos_e);
                           left_ff  <= CW'(cnt_e - pos_e);
                           state_ff <= ST_WALK;
                        end
                     end
                     ACT_LOCATE: begin
                        if (count_ff == '0) begin
                           rsp_status_ff <= STS_NOT_FOUND;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           idx_ff   <= '0;
                           left_ff  <= count_ff;
                           state_ff <= ST_WALK;
                        end
                     end
                     ACT_GET: begin
                        if ((pos_e == '0) || (pos_e > cnt_e)) begin
                           rsp_status_ff <= STS_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           idx_ff   <= AW'(pos_e - EW'(1));
                           left_ff  <= CW'(1);
                           state_ff <= ST_WALK;
                        end
                     end
                     ACT_CLEAR: begin
                        count_ff     <= '0;
                        rsp_len_ff   <= '0;
                        rsp_empty_ff <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_WALK: begin
               // issue the next read, or let the pipe drain
               if (left_ff != '0) begin
                  pend_ff  <= 1'b1;
                  paddr_ff <= idx_ff;
                  idx_ff   <= (act_ff == ACT_INSERT) ? idx_ff - AW'(1) : idx_ff + AW'(1);
                  left_ff  <= left_ff - CW'(1);
               end else begin
                  pend_ff <= 1'b0;
               end

               if (pend_ff && (act_ff == ACT_LOCATE) && (ram_rdata == val_ff)) begin
                  // first hit wins: abandon the read still in flight
                  rsp_found_ff <= found_e[7:0];
                  rsp_valid_ff <= 1'b1;
                  pend_ff      <= 1'b0;
                  left_ff      <= '0;
                  state_ff     <= ST_IDLE;
               end else if (pend_ff && (act_ff == ACT_GET)) begin
                  rsp_element_ff <= ram_rdata;
                  rsp_valid_ff   <= 1'b1;
                  pend_ff        <= 1'b0;
                  state_ff       <= ST_IDLE;
               end else if (walk_end) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  case (act_ff)
                     ACT_INSERT: begin
                        count_ff     <= count_ff + CW'(1);
                        rsp_len_ff   <= low8(count_ff + CW'(1));
                        rsp_empty_ff <= 1'b0;
                     end
                     ACT_DELETE: begin
                        count_ff     <= count_ff - CW'(1);
                        rsp_len_ff   <= low8(count_ff - CW'(1));
                        rsp_empty_ff <= (count_ff == CW'(1));
                     end
                     default: begin
                        // locate ran off the end of the list
                        rsp_status_ff <= STS_NOT_FOUND;
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_element        = $signed(rsp_element_ff);
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_len_ff;
   assign rsp_is_empty       = rsp_empty_ff;

endmodule

### bench/testbench.sv
// Self-checking testbench for the sequential list engine core.
`timescale 1ns / 1ps

module testbench;
   import sle_pkg::*;

   localparam int LIST_CAP     = DEF_CAPACITY;
   localparam int RANDOM_CMDS  = 1800;
   localparam int SEGMENT_LEN  = 180;
   localparam int DRAIN_CYCLES = LIST_CAP + 16;

   // Codes the engine does not decode; it must answer them with the current list.
   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] element;
      logic [7:0]  found_pos;
      logic [7:0]  length;
      logic        is_empty;
   } rsp_beat_t;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  position;
      logic [31:0] value;
      logic        typed;
      rsp_beat_t   want;
   } stim_row_t;

   // Directed rows. Rows with typed set carry the answer written out by hand;
   // the others are checked against the list predictor.
   localparam int DIR_ROWS = 26;
   localparam stim_row_t DIRECTED [DIR_ROWS] = '{
      // empty list: get, delete and locate all fail
      '{ACT_GET,    8'd1,   32'h0000_0000, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd0, 1'b1}},
      '{ACT_DELETE, 8'd1,   32'h0000_0000, 1'b1, '{STS_EMPTY,     32'h0, 8'd0, 8'd0, 1'b1}},
      '{ACT_LOCATE, 8'd0,   32'h0000_0000, 1'b1, '{STS_NOT_FOUND, 32'h0, 8'd0, 8'd0, 1'b1}},
      // insert outside 1..length+1
      '{ACT_INSERT, 8'd0,   32'h0000_0005, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd0, 1'b1}},
      '{ACT_INSERT, 8'd2,   32'h0000_0005, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd0, 1'b1}},
      // extremes of the value field
      '{ACT_INSERT, 8'd1,   32'h7FFF_FFFF, 1'b1, '{STS_OK,        32'h0, 8'd0, 8'd1, 1'b0}},
      '{ACT_INSERT, 8'd2,   32'h8000_0000, 1'b1, '{STS_OK,        32'h0, 8'd0, 8'd2, 1'b0}},
      '{ACT_INSERT, 8'd1,   32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_INSERT, 8'd255, 32'h0000_0009, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd3, 1'b0}},
      // duplicate value in the middle, so locate must report the first copy
      '{ACT_INSERT, 8'd2,   32'h7FFF_FFFF, 1'b0, '0},
      '{ACT_GET,    8'd1,   32'h0000_0000, 1'b0, '0},
      '{ACT_GET,    8'd4,   32'h0000_0000, 1'b0, '0},
      '{ACT_GET,    8'd5,   32'h0000_0000, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd4, 1'b0}},
      '{ACT_GET,    8'd255, 32'h0000_0000, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd4, 1'b0}},
      '{ACT_LOCATE, 8'd0,   32'h7FFF_FFFF, 1'b0, '0},
      '{ACT_LOCATE, 8'd0,   32'h0000_3039, 1'b1, '{STS_NOT_FOUND, 32'h0, 8'd0, 8'd4, 1'b0}},
      // delete outside 1..length, then one in the middle
      '{ACT_DELETE, 8'd0,   32'h0000_0000, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd4, 1'b0}},
      '{ACT_DELETE, 8'd5,   32'h0000_0000, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd4, 1'b0}},
      '{ACT_DELETE, 8'd2,   32'h0000_0000, 1'b0, '0},
      // unused codes leave the list alone
      '{ACT_SPARE_5, 8'd1,  32'h0000_0001, 1'b0, '0},
      '{ACT_SPARE_6, 8'd255, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_SPARE_7, 8'd0,  32'h8000_0000, 1'b0, '0},
      // clear, twice, and a get that must not see the stale entries
      '{ACT_CLEAR,  8'd0,   32'h0000_0000, 1'b1, '{STS_OK,        32'h0, 8'd0, 8'd0, 1'b1}},
      '{ACT_CLEAR,  8'd7,   32'h0000_0000, 1'b1, '{STS_OK,        32'h0, 8'd0, 8'd0, 1'b1}},
      '{ACT_GET,    8'd1,   32'h0000_0000, 1'b1, '{STS_BAD_POS,   32'h0, 8'd0, 8'd0, 1'b1}},
      '{ACT_INSERT, 8'd1,   32'h0000_0000, 1'b0, '0}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_action;
   logic [7:0]         req_position;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_element;
   logic [7:0]         rsp_found_position;
   logic [7:0]         rsp_list_length;
   logic               rsp_is_empty;

   // Predictor state: the list as the engine should hold it, position 1 first.
   logic [31:0] list_q[$];
   // Answers owed by the engine, in command order.
   rsp_beat_t   pending_rsp[$];

   int mismatch_count = 0;
   int cmd_count      = 0;
   int peak_length    = 0;
   int status_count [5] = '{0, 0, 0, 0, 0};

   sequential_list_engine_core #(
      .CAPACITY (LIST_CAP)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_element        (rsp_element),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .rsp_is_empty       (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Apply one command to the predicted list and return the answer it owes.
   function automatic rsp_beat_t apply_list_cmd(logic [2:0] act, logic [7:0] pos,
                                                logic [31:0] val);
      rsp_beat_t r;
      int        n;
      int        p;
      n           = list_q.size();
      p           = int'(pos);
      r.status    = STS_OK;
      r.element   = '0;
      r.found_pos = '0;
      case (act)
         ACT_INSERT: begin
            if (p < 1 || p > n + 1) r.status = STS_BAD_POS;
            else if (n >= LIST_CAP) r.status = STS_FULL;
            else list_q.insert(p - 1, val);
         end
         ACT_DELETE: begin
            if (n == 0) r.status = STS_EMPTY;
            else if (p < 1 || p > n) r.status = STS_BAD_POS;
            else list_q.delete(p - 1);
         end
         ACT_LOCATE: begin
            r.status = STS_NOT_FOUND;
            for (int k = 0; k < n; k++) begin
               if (r.status == STS_NOT_FOUND && list_q[k] == val) begin
                  r.status    = STS_OK;
                  r.found_pos = 8'(k + 1);
               end
            end
         end
         ACT_GET: begin
            if (p < 1 || p > n) r.status = STS_BAD_POS;
            else r.element = list_q[p - 1];
         end
         ACT_CLEAR: begin
            list_q.delete();
         end
         default: begin
         end
      endcase
      r.length   = 8'(list_q.size());
      r.is_empty = (list_q.size() == 0);
      return r;
   endfunction

   // Values lean on the extremes and on a small range so that duplicates occur.
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0:       w = 32'h7FFF_FFFF;
         1:       w = 32'h8000_0000;
         2:       w = 32'h0000_0000;
         3:       w = 32'hFFFF_FFFF;
         4, 5, 6: w = 32'($urandom_range(0, 15));
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Mostly legal positions for the current length; now and then any byte at all.
   function automatic logic [7:0] pick_position(int upper);
      if (upper < 1 || $urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(1, upper));
   endfunction

   task automatic pick_random_cmd(input mix_t mix, output logic [2:0] act,
                                  output logic [7:0] pos, output logic [31:0] val);
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      n    = list_q.size();
      case (mix)
         MIX_GROW:     act = (roll < 75) ? ACT_INSERT : (roll < 82) ? ACT_DELETE :
                             (roll < 90) ? ACT_LOCATE : (roll < 97) ? ACT_GET    :
                             3'($urandom_range(5, 7));
         MIX_SHRINK:   act = (roll < 15) ? ACT_INSERT : (roll < 70) ? ACT_DELETE :
                             (roll < 82) ? ACT_LOCATE : (roll < 94) ? ACT_GET    :
                             (roll < 96) ? ACT_CLEAR  : 3'($urandom_range(5, 7));
         default:      act = (roll < 40) ? ACT_INSERT : (roll < 70) ? ACT_DELETE :
                             (roll < 82) ? ACT_LOCATE : (roll < 94) ? ACT_GET    :
                             (roll < 96) ? ACT_CLEAR  : 3'($urandom_range(5, 7));
      endcase
      val = pick_word();
      case (act)
         ACT_INSERT: pos = pick_position(n + 1);
         ACT_DELETE,
         ACT_GET:    pos = pick_position(n);
         default:    pos = 8'($urandom_range(0, 255));
      endcase
      // Search mostly for values that are present, so hits land at every depth.
      if (act == ACT_LOCATE && n > 0 && $urandom_range(0, 99) < 70)
         val = list_q[$urandom_range(0, n - 1)];
   endtask

   // Present one command beat, hold it until the engine takes it, then log the answer owed.
   task automatic issue_cmd(input logic [2:0] act, input logic [7:0] pos,
                            input logic [31:0] val, input logic typed,
                            input rsp_beat_t want);
      rsp_beat_t predicted;
      req_action   <= act;
      req_position <= pos;
      req_value    <= val;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_list_cmd(act, pos, val);
      pending_rsp.push_back(typed ? want : predicted);
      cmd_count++;
   endtask

   // Now and then drop start between commands, about 38 times in a hundred.
   task automatic sender_gap(input bit allow);
      int n;
      if (allow && $urandom_range(0, 99) < 38) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold the sender until every answer owed has come back.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Result checker: every strobe must match the oldest answer owed, field by field.
   always @(posedge clock) begin
      rsp_beat_t want;
      if (!reset && rsp_valid) begin
         if (rsp_status <= STS_NOT_FOUND) status_count[rsp_status]++;
         if (int'(rsp_list_length) > peak_length) peak_length = int'(rsp_list_length);
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result beat, status %0d length %0d",
                     $time, rsp_status, rsp_list_length);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
            end
            if (rsp_element !== want.element) begin
               mismatch_count++;
               $display("%0t: element expected %0d actual %0d",
                        $time, $signed(want.element), rsp_element);
            end
            if (rsp_found_position !== want.found_pos) begin
               mismatch_count++;
               $display("%0t: found_position expected %0d actual %0d",
                        $time, want.found_pos, rsp_found_position);
            end
            if (rsp_list_length !== want.length) begin
               mismatch_count++;
               $display("%0t: list_length expected %0d actual %0d",
                        $time, want.length, rsp_list_length);
            end
            if (rsp_is_empty !== want.is_empty) begin
               mismatch_count++;
               $display("%0t: is_empty expected %0d actual %0d",
                        $time, want.is_empty, rsp_is_empty);
            end
         end
      end
   end

   // Main sequence: reset, directed table, random segments, drain, verdict.
   initial begin
      logic [2:0]  act;
      logic [7:0]  pos;
      logic [31:0] val;
      mix_t        mix;
      int          seg;
      bit          allow_gaps;

      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= ACT_INSERT;
      req_position <= '0;
      req_value    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with the usual random gaps.
      for (int i = 0; i < DIR_ROWS; i++) begin
         issue_cmd(DIRECTED[i].action, DIRECTED[i].position, DIRECTED[i].value,
                   DIRECTED[i].typed, DIRECTED[i].want);
         sender_gap(1'b1);
      end
      wait_drained();

      // Random part in segments: grow, balanced, grow, shrink, repeated.
      // Growing segments fill the list to capacity so full rejects occur;
      // the fifth and sixth segments run with start held high throughout.
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         seg = i / SEGMENT_LEN;
         if (i != 0 && i % SEGMENT_LEN == 0) wait_drained();
         case (seg % 4)
            0, 2:    mix = MIX_GROW;
            1:       mix = MIX_BALANCED;
            default: mix = MIX_SHRINK;
         endcase
         allow_gaps = !(seg == 4 || seg == 5);
         pick_random_cmd(mix, act, pos, val);
         issue_cmd(act, pos, val, 1'b0, '0);
         sender_gap(allow_gaps);
      end

      // Let the last answers arrive, then watch a little longer for strays.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands (%0d directed), list length peaked at %0d of %0d",
               cmd_count, DIR_ROWS, peak_length, LIST_CAP);
      $display("answers: ok %0d, bad position %0d, full %0d, empty %0d, not found %0d",
               status_count[0], status_count[1], status_count[2], status_count[3],
               status_count[4]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a third of this.
   initial begin
      #15_000_000;
      $display("timeout with %0d answers still owed", pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
